// ===== sv/dre_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta regression features: shared definitions
// Field widths, register indexes, configuration record, queue status and
// back-end state codes used across the delta regression block.
// ----------------------------------------------------------------------------
package dre_pkg;

   localparam int COEFF_W    = 16;
   localparam int DW_W       = 3;
   localparam int NORM_W     = 10;
   localparam int FD_W       = 7;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_NORM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_DIM = 2'd2;

   localparam logic signed [COEFF_W-1:0] SAT_POS = 16'sh7FFF;
   localparam logic signed [COEFF_W-1:0] SAT_NEG = 16'sh8000;

   localparam logic [DW_W-1:0]   RESET_DELTA_WIDTH = 3'd2;
   localparam logic [NORM_W-1:0] RESET_DELTA_NORM  = 10'd10;
   localparam logic [FD_W-1:0]   RESET_FEATURE_DIM = 7'd16;

   typedef struct packed {
      logic [DW_W-1:0]   delta_width;
      logic [NORM_W-1:0] delta_norm;
      logic [FD_W-1:0]   feature_dim;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_START,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

// ===== sv/delta_regression_features_top.sv =====
// ----------------------------------------------------------------------------
// Delta regression features
// Streaming delta (regression) coefficients over a ring of feature frames.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_coeff_in
//   rsp_      out        rsp_valid / rsp_stall  rsp_delta_out, rsp_coeff_index,
//                                               rsp_frame_end
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// The back end handles one item at a time; its pace is set by the iterative
// divider, which resolves four quotient bits per cycle, and by the one tap
// pair read per cycle from the frame ring.
// After reset all (2*MAX_WIDTH+1)*MAX_DIM entries of the frame ring (576 by
// default) are swept with zeros; req_stall stays high during the sweep, while
// register writes are taken as usual.
// The front end takes an item in any cycle in which the two-entry queue has
// room and the sweep is over, so input stalls only when the queue is full or
// during the sweep; a held output result stalls the back end alone.
//
// Each coefficient is written into the ring slot of the frame now arriving.
// The result for that item is the delta, at the same dimension, of the frame
// W frames earlier: the sum over k of k times the difference of the taps k
// frames after and before it, divided by delta_norm with truncation toward
// zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module delta_regression_features_top import dre_pkg::*; #(
   parameter int MAX_WIDTH = 4,
   parameter int MAX_DIM   = 64
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COEFF_W-1:0] req_coeff_in,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COEFF_W-1:0] rsp_delta_out,
   output logic [IDX_W-1:0]          rsp_coeff_index,
   output logic                      rsp_frame_end,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RING    = 2 * MAX_WIDTH + 1;
   localparam int SLOT_W  = $clog2(RING);
   localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int ENTRY_W = COEFF_W + 1 + WW + SLOT_W + DIM_W;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type queue_status;
   logic             queue_push, queue_pop;
   logic [ENTRY_W-1:0] queue_push_data, queue_pop_data;
   logic             clearing;

   // Register writes are always taken; the configuration is expected to
   // change only while no item is in flight.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELTA_WIDTH: cfg_in.delta_width = csr_wdata[DW_W-1:0];
            CSR_DELTA_NORM:  cfg_in.delta_norm  = csr_wdata[NORM_W-1:0];
            CSR_FEATURE_DIM: cfg_in.feature_dim = csr_wdata[FD_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_width <= RESET_DELTA_WIDTH;
         cfg_ff.delta_norm  <= RESET_DELTA_NORM;
         cfg_ff.feature_dim <= RESET_FEATURE_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: position tracking and clamping of width and dimension.
   dre_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_DIM  (MAX_DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_coeff_in (req_coeff_in),
      .cfg          (cfg_ff),
      .status       (queue_status),
      .clearing     (clearing),
      .push         (queue_push),
      .push_data    (queue_push_data)
   );

   // Queue between the two halves so that each can stall on its own.
   dre_fifo #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_push_data),
      .pop       (queue_pop),
      .pop_data  (queue_pop_data),
      .status    (queue_status)
   );

   // Back end: frame ring, tap accumulation, division and output register.
   dre_back #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_DIM  (MAX_DIM)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .delta_norm      (cfg_ff.delta_norm),
      .status          (queue_status),
      .pop             (queue_pop),
      .pop_data        (queue_pop_data),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_delta_out   (rsp_delta_out),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ===== sv/dre_fifo.sv =====
// ----------------------------------------------------------------------------
// Delta regression features: item queue
// Short first-in first-out queue that separates the front end from the
// back end.
// ----------------------------------------------------------------------------
module dre_fifo import dre_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
      status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_data     = entry_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/dre_front.sv =====
// ----------------------------------------------------------------------------
// Delta regression features: front end
// Accepts coefficients, tracks the dimension and ring slot being written,
// and queues each item with its position and effective regression width.
// ----------------------------------------------------------------------------
module dre_front import dre_pkg::*; #(
   parameter  int MAX_WIDTH = 4,
   parameter  int MAX_DIM   = 64,
   localparam int RING      = 2 * MAX_WIDTH + 1,
   localparam int SLOT_W    = $clog2(RING),
   localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int WW        = $clog2(MAX_WIDTH + 1),
   localparam int ENTRY_W   = COEFF_W + 1 + WW + SLOT_W + DIM_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COEFF_W-1:0] req_coeff_in,
   input  cfg_type                   cfg,
   input  queue_status_type          status,
   input  logic                      clearing,
   output logic                      push,
   output logic [ENTRY_W-1:0]        push_data
);

   localparam int CMP_W = DIM_W + 8;

   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WW-1:0]     width_eff;
   logic [CMP_W-1:0]  dim_eff;
   logic              last;

   always_comb begin
      req_stall = status.full || clearing;
      push      = req_valid && !req_stall;

      // Out-of-range widths and dimensions are clamped into the legal span.
      if (cfg.delta_width == '0) begin
         width_eff = WW'(1);
      end else if (CMP_W'(cfg.delta_width) > CMP_W'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(cfg.delta_width);
      end

      if (cfg.feature_dim == '0) begin
         dim_eff = CMP_W'(1);
      end else if (CMP_W'(cfg.feature_dim) > CMP_W'(MAX_DIM)) begin
         dim_eff = CMP_W'(MAX_DIM);
      end else begin
         dim_eff = CMP_W'(cfg.feature_dim);
      end

      // A shrunk dimension count ends the frame at once.
      last = (CMP_W'(dim_ff) + CMP_W'(1)) >= dim_eff;

      dim_in  = dim_ff;
      slot_in = slot_ff;
      if (push) begin
         if (last) begin
            dim_in  = '0;
            slot_in = (slot_ff == SLOT_W'(RING - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end else begin
            dim_in  = dim_ff + DIM_W'(1);
         end
      end

      push_data = {req_coeff_in, last, width_eff, slot_ff, dim_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= '0;
         slot_ff <= '0;
      end else begin
         dim_ff  <= dim_in;
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== sv/dre_div.sv =====
// ----------------------------------------------------------------------------
// Delta regression features: iterative divider
// Signed by unsigned division truncating toward zero, four quotient bits
// per cycle, with the quotient saturated to a signed coefficient.
// ----------------------------------------------------------------------------
module dre_div import dre_pkg::*; #(
   parameter int SUM_W = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic [NORM_W-1:0]         divisor,
   output logic                      done,
   output logic signed [COEFF_W-1:0] quotient
);

   localparam int DIV_BITS = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int CYCLES   = DIV_BITS / DIV_STEPS;
   localparam int CNT_W    = (CYCLES > 1) ? $clog2(CYCLES) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                neg_ff;
   logic [DIV_BITS-1:0] quo_ff, quo_next;
   logic [NORM_W-1:0]   rem_ff, rem_next;
   logic [NORM_W-1:0]   div_ff;
   logic [NORM_W:0]     trial;
   logic [SUM_W-1:0]    mag;

   always_comb begin
      mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

      // Restoring division, one quotient bit per step.
      quo_next = quo_ff;
      rem_next = rem_ff;
      trial    = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial    = {rem_next, quo_next[DIV_BITS-1]};
         quo_next = {quo_next[DIV_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial       = trial - {1'b0, div_ff};
            quo_next[0] = 1'b1;
         end
         rem_next = trial[NORM_W-1:0];
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      if (!neg_ff) begin
         quotient = (quo_ff > DIV_BITS'(32767)) ? SAT_POS : $signed(quo_ff[COEFF_W-1:0]);
      end else begin
         quotient = (quo_ff > DIV_BITS'(32768)) ? SAT_NEG
                  : $signed(~quo_ff[COEFF_W-1:0] + COEFF_W'(1));
      end
      done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= DIV_BITS'(mag);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_next;
         rem_ff <= rem_next;
      end
   end

endmodule

// ===== sv/dre_back.sv =====
// ----------------------------------------------------------------------------
// Delta regression features: back end
// Owns the frame ring, clears it after reset, stores each coefficient,
// accumulates the weighted tap differences, divides and delivers results.
// ----------------------------------------------------------------------------
module dre_back import dre_pkg::*; #(
   parameter  int MAX_WIDTH = 4,
   parameter  int MAX_DIM   = 64,
   localparam int RING      = 2 * MAX_WIDTH + 1,
   localparam int SLOT_W    = $clog2(RING),
   localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int WW        = $clog2(MAX_WIDTH + 1),
   localparam int ENTRY_W   = COEFF_W + 1 + WW + SLOT_W + DIM_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [NORM_W-1:0]         delta_norm,
   input  queue_status_type          status,
   output logic                      pop,
   input  logic [ENTRY_W-1:0]        pop_data,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COEFF_W-1:0] rsp_delta_out,
   output logic [IDX_W-1:0]          rsp_coeff_index,
   output logic                      rsp_frame_end
);

   localparam int DEPTH  = RING * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SW1    = SLOT_W + 1;
   localparam int SUM_W  = 18 + $clog2(MAX_WIDTH * (MAX_WIDTH + 1) / 2);
   localparam int PROD_W = COEFF_W + 2 + WW;

   back_state_type state_ff, state_in;

   logic signed [COEFF_W-1:0] store_mem [DEPTH];
   logic signed [COEFF_W-1:0] rd_right_ff, rd_left_ff;

   logic signed [COEFF_W-1:0] coeff_ff;
   logic                      last_ff;
   logic [WW-1:0]             w_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [DIM_W-1:0]          d_ff;

   logic [WW-1:0]             k_ff, rd_k_ff;
   logic                      rd_valid_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [ADDR_W-1:0]         clr_cnt_ff;
   logic signed [COEFF_W-1:0] result_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COEFF_W-1:0] rsp_delta_ff;
   logic [IDX_W-1:0]          rsp_index_ff;
   logic                      rsp_frame_end_ff;

   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic signed [COEFF_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]         addr_right, addr_left;
   logic                      div_start, div_done;
   logic signed [COEFF_W-1:0] div_quotient;
   logic [NORM_W-1:0]         norm_eff;
   logic                      rsp_load;
   logic signed [COEFF_W:0]   diff;
   logic signed [PROD_W-1:0]  prod;
   logic [DIM_W+IDX_W-1:0]    dim_wide;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                 input logic [DIM_W-1:0]  dd);
      addr_of = ADDR_W'(int'(s) * MAX_DIM + int'(dd));
   endfunction

   function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] s,
                                                   input logic [SW1-1:0]    back);
      logic [SW1-1:0] t;
      t = {1'b0, s} + SW1'(RING) - back;
      if (t >= SW1'(RING)) begin
         t = t - SW1'(RING);
      end
      ring_back = t[SLOT_W-1:0];
   endfunction

   always_comb begin
      addr_right = addr_of(ring_back(slot_ff, SW1'(w_ff) - SW1'(k_ff)), d_ff);
      addr_left  = addr_of(ring_back(slot_ff, SW1'(w_ff) + SW1'(k_ff)), d_ff);
      norm_eff   = (delta_norm == '0) ? NORM_W'(1) : delta_norm;
      diff       = {rd_right_ff[COEFF_W-1], rd_right_ff} - {rd_left_ff[COEFF_W-1], rd_left_ff};
      prod       = diff * $signed({1'b0, rd_k_ff});
      dim_wide   = {IDX_W'(0), d_ff};
      clearing   = (state_ff == ST_CLEAR);
   end

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = addr_of(slot_ff, d_ff);
      mem_wdata = coeff_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!status.empty) begin
               pop      = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (k_ff == w_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   // Frame ring: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_right_ff <= store_mem[addr_right];
      rd_left_ff  <= store_mem[addr_left];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         {coeff_ff, last_ff, w_ff, slot_ff, d_ff} <= pop_data;
      end
      rd_k_ff <= k_ff;
      if (state_ff == ST_WRITE) begin
         k_ff   <= WW'(1);
         sum_ff <= '0;
      end else begin
         if (state_ff == ST_READ) begin
            k_ff <= k_ff + WW'(1);
         end
         if (rd_valid_ff) begin
            sum_ff <= sum_ff + SUM_W'(prod);
         end
      end
      if (div_done) begin
         result_ff <= div_quotient;
      end
      if (rsp_load) begin
         rsp_delta_ff     <= result_ff;
         rsp_index_ff     <= dim_wide[IDX_W-1:0];
         rsp_frame_end_ff <= last_ff;
      end
   end

   dre_div #(
      .SUM_W(SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (norm_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_delta_out   = rsp_delta_ff;
   assign rsp_coeff_index = rsp_index_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;

`ifndef SYNTHESIS
   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((k_ff != '0) && (k_ff <= w_ff)))
      else $error("tap index outside the regression width");

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == ST_READ))
      else $error("tap data accumulated without a read issue");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result presented without a finished item");
`endif

endmodule
